// ----- rtl/spq_pkg.sv -----
// Shared types, widths and codes of the sorted priority queue.
package spq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned VAL_W  = 8;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VAL_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0]  out_value;
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_rsp;

endpackage

// ----- rtl/spq_if.sv -----
// Valid/ready channel carrying one request or result payload.
interface spq_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sorted_priority_queue_unit.sv -----
// Top level of the sorted priority queue: sequencer, fill count and result register.
//
// Usage: requests arrive on i_req (command, item_value); results leave on o_rsp
// (out_value, position, status, last). Both are valid/ready channels; a transfer
// happens on a rising edge with valid and ready high.
// i_req.ready is high only while the sequencer is idle, so one request is
// worked on at a time. Every pass over the store goes through the single
// store read port, whose registered data needs a read and a compare state per entry:
//   insert  : scan from the tail, moving each entry greater than the value up,
//             then write the value above a smaller or equal entry, or at the head
//   remove  : read the head, then shift every entry down
//   display : one result per entry, each held while the output stalls
//   full or empty: status result only; unused command: no result
// Results sit in an output register; the next request is taken while a final
// result still waits there. If the receiver stalls, the sequencer holds before
// loading its next result until the register frees up.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// store contents are not cleared, only the first fill entries are ever read.
// Command code three is accepted and gives no result.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_if.sink   i_req,
    spq_if.source o_rsp
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_WR0,
        S_FIN,
        S_DOUT
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_head, n_head;
    logic [AW-1:0]    r_idx, n_idx;
    t_rsp             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic [VAL_W-1:0] w_rdata;
    logic [AW:0]      w_idx_inc;
    logic             w_at_tail;
    logic             w_slot_free;

    spq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_idx_inc   = {1'b0, r_idx} + 1'b1;
    assign w_at_tail   = (w_idx_inc == (AW + 1)'(r_fill));
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_head      = r_head;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_val;

        // Drop the result register once the receiver takes it.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd  = i_req.data.command;
                    n_val  = i_req.data.item_value;
                    n_pend = '{out_value: '0, position: '0, status: ST_OK, last: 1'b1};
                    case (i_req.data.command)
                        CMD_INSERT: begin
                            if (r_fill == CW'(CAPACITY)) begin
                                n_pend.status = ST_FULL;
                                n_state       = S_FIN;
                            end else if (r_fill == '0) begin
                                n_state = S_WR0;
                            end else begin
                                // Scan from the tail toward the head.
                                n_idx   = AW'(r_fill - 1'b1);
                                n_state = S_RD;
                            end
                        end
                        CMD_REMOVE, CMD_DISPLAY: begin
                            if (r_fill == '0) begin
                                n_pend.status = ST_EMPTY;
                                n_state       = S_FIN;
                            end else begin
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_CMP;
            end

            S_CMP: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        w_we = 1'b1;
                        w_waddr = AW'(w_idx_inc);
                        if (w_rdata > r_val) begin
                            // Move the larger entry up one place.
                            w_wdata = w_rdata;
                            if (r_idx == '0) begin
                                n_state = S_WR0;
                            end else begin
                                n_idx   = r_idx - 1'b1;
                                n_state = S_RD;
                            end
                        end else begin
                            w_wdata = r_val;
                            n_state = S_FIN;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_idx == '0) begin
                            n_head = w_rdata;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_idx - 1'b1;
                            w_wdata = w_rdata;
                        end
                        if (w_at_tail) begin
                            n_pend.out_value = (r_idx == '0) ? w_rdata : r_head;
                            n_state          = S_FIN;
                        end else begin
                            n_idx   = AW'(w_idx_inc);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_pend = '{out_value: w_rdata, position: POS_W'(w_idx_inc),
                                   status: ST_OK, last: w_at_tail};
                        n_state = S_DOUT;
                    end
                endcase
            end

            S_WR0: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_val;
                n_state = S_FIN;
            end

            S_FIN: begin
                // Load the final result and commit the new fill count together.
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    if (r_pend.status == ST_OK) begin
                        if (r_cmd == CMD_INSERT) begin
                            n_fill = r_fill + 1'b1;
                        end else if (r_cmd == CMD_REMOVE) begin
                            n_fill = r_fill - 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end

            S_DOUT: begin
                // Hold until the result register frees up, then advance.
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    if (r_pend.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = AW'(w_idx_inc);
                        n_state = S_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_val  <= n_val;
        r_head <= n_head;
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status == ST_FULL) |-> (r_fill == CW'(CAPACITY)))
        else $error("full status reported while store not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status == ST_EMPTY) |-> (r_fill == '0))
        else $error("empty status reported while store holds entries");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.position != '0) |->
            (o_rsp.data.status == ST_OK && r_state != S_IDLE || o_rsp.data.last))
        else $error("display position outside a display pass");
`endif
endmodule

// ----- rtl/spq_store.sv -----
// Entry store: one write port, one read port with registered read data.
module spq_store
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = CAPACITY_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);
    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
